>>> hw/rtl/stcm_pkg.sv
// Shared types, constants and table helper for the scalar-to-RGB colormap core.
package stcm_pkg;

   // Fixed-point format of the samples; only the small epsilon follows from it
   localparam int FRACTION_BITS = 16;
   localparam int EPS_RAW = ((1 << FRACTION_BITS) + 5000) / 10000;
   localparam int EPS = (EPS_RAW < 1) ? 1 : EPS_RAW;

   // Divider geometry: 17 quotient bits, 50-bit partial remainder
   localparam int QW = 17;
   localparam int NW = 50;

   // Heatmap breakpoints scaled by 65536 (h = 100 * t)
   localparam logic [31:0] H33  = 32'd2162688;
   localparam logic [31:0] H66  = 32'd4325376;
   localparam logic [31:0] H136 = 32'd8912896;

   // Reciprocals for divide by 33, 136 and 1000
   localparam logic [16:0] K33   = 17'd127101;
   localparam logic [16:0] K136  = 17'd30841;
   localparam int          KSH   = 22;
   localparam logic [18:0] K1000 = 19'd268436;
   localparam int          K1000_SH = 28;

   // Divergence tint, per mille
   localparam logic [26:0] DIV_FULL = 27'd65536000;
   localparam logic [9:0] DIV_BASE [3]     = '{10'd20, 10'd20, 10'd25};
   localparam logic [9:0] DIV_TINT_POS [3] = '{10'd1000, 10'd240, 10'd140};
   localparam logic [9:0] DIV_TINT_NEG [3] = '{10'd120, 10'd380, 10'd1000};

   typedef enum logic [2:0] {
      OP_RAINBOW  = 3'd0,
      OP_GREY     = 3'd1,
      OP_HEAT     = 3'd2,
      OP_DIVERGE  = 3'd3,
      OP_VELOCITY = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      HS_LOW  = 2'd0,
      HS_MID  = 2'd1,
      HS_HIGH = 2'd2
   } hseg_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   // Control that rides along the divider stages
   typedef struct packed {
      op_type op;
      logic   zden;   // denominator is zero
      logic   nden;   // denominator is negative
      logic   neg;    // quotient is negative
      logic   sat;    // quotient >= 2^17
      logic   sneg;   // sample is negative
   } dctl_type;

   // floor(65536 * (i/d)^0.65), exact: largest y with y^20 * d^13 <= i^13 * 2^320
   function automatic logic [16:0] pow_entry(input int unsigned i, input int unsigned d);
      logic [511:0] rhs;
      logic [511:0] lhs;
      logic [17:0]  lo;
      logic [17:0]  hi;
      logic [17:0]  mid;
      rhs = 512'd1;
      for (int k = 0; k < 13; k++) rhs = rhs * 512'(i);
      rhs = rhs << 320;
      lo = 18'd0;
      hi = 18'd65536;
      for (int n = 0; n < 18; n++) begin
         if (lo < hi) begin
            mid = (lo + hi + 18'd1) >> 1;
            lhs = 512'd1;
            for (int k = 0; k < 20; k++) lhs = lhs * 512'(mid);
            for (int k = 0; k < 13; k++) lhs = lhs * 512'(d);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 18'd1;
         end
      end
      return lo[16:0];
   endfunction

endpackage

>>> hw/rtl/scalar_to_rgb_colormap_core.sv
// Scalar-to-RGB colormap core: five palettes, one word per clock, fully pipelined.
// Takes one word per clock and returns one RGB word per input word, in order. rsp_valid
// rises once the word has passed through 28 register stages after acceptance: four
// preparation stages, a scaling stage and a 17-stage restoring divider (one quotient
// bit per stage, which sets the depth), and six palette stages. A stalled result holds
// the whole pipeline; otherwise a new word enters every cycle. The power table holds
// POWER_TABLE_ENTRIES constant entries built at elaboration.
module scalar_to_rgb_colormap_core #(
   parameter int POWER_TABLE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_sample,
   input  logic [31:0] req_range_low,
   input  logic [31:0] req_range_high,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);
   import stcm_pkg::*;

   localparam int N_ENT = POWER_TABLE_ENTRIES;
   localparam int DEN_T = (N_ENT > 1) ? N_ENT - 1 : 1;
   localparam int IW    = (N_ENT > 1) ? $clog2(N_ENT) : 1;
   localparam int PW    = 18 + IW;

   // Power table, constant content
   logic [16:0] pow_rom [N_ENT];
   for (genvar gi = 0; gi < N_ENT; gi++) begin : g_rom
      localparam logic [16:0] PV = pow_entry(gi, DEN_T);
      assign pow_rom[gi] = PV;
   end

   // Global advance: everything moves unless the output word is held
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;

   // ---------------- stage 0: input capture
   logic               s0_v_ff;
   op_type             s0_op_ff;
   logic signed [31:0] s0_s_ff, s0_lo_ff, s0_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) s0_v_ff <= 1'b0;
      else if (adv) s0_v_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_op_ff <= op_type'(req_operation);
         s0_s_ff  <= req_sample;
         s0_lo_ff <= req_range_low;
         s0_hi_ff <= req_range_high;
      end
   end

   // ---------------- stage A: differences and clamp compare
   logic               a_v_ff;
   op_type             a_op_ff;
   logic signed [32:0] a_delta_ff, a_delta_in;
   logic signed [32:0] a_diff_ff, a_diff_in;
   logic               a_above_ff, a_above_in;
   logic signed [31:0] a_scale_ff, a_scale_in;
   logic signed [31:0] a_s_ff;

   always_comb begin
      a_delta_in = 33'(s0_hi_ff) - 33'(s0_lo_ff);
      a_diff_in  = 33'(s0_s_ff) - 33'(s0_lo_ff);
      a_above_in = 34'(s0_s_ff) > (34'(s0_hi_ff) - 34'(EPS));
      a_scale_in = (s0_hi_ff < 32'(EPS)) ? 32'(EPS) : s0_hi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (adv) a_v_ff <= s0_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         a_op_ff    <= s0_op_ff;
         a_delta_ff <= a_delta_in;
         a_diff_ff  <= a_diff_in;
         a_above_ff <= a_above_in;
         a_scale_ff <= a_scale_in;
         a_s_ff     <= s0_s_ff;
      end
   end

   // ---------------- stage B: pick dividend and divisor
   logic               b_v_ff;
   op_type             b_op_ff;
   logic signed [33:0] b_x_ff, b_x_in;
   logic signed [33:0] b_den_ff, b_den_in;
   logic               b_sneg_ff;

   always_comb begin
      case (a_op_ff)
         OP_RAINBOW, OP_VELOCITY: begin
            b_x_in = a_above_ff ? (34'(a_delta_ff) - 34'(EPS)) : 34'(a_diff_ff);
            if (b_x_in < 0) b_x_in = '0;
            b_den_in = 34'(a_delta_ff);
         end
         OP_DIVERGE: begin
            b_x_in   = 34'(a_s_ff);
            b_den_in = 34'(a_scale_ff);
         end
         default: begin
            b_x_in   = 34'(a_diff_ff);
            b_den_in = 34'(a_delta_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (adv) b_v_ff <= a_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         b_op_ff   <= a_op_ff;
         b_x_ff    <= b_x_in;
         b_den_ff  <= b_den_in;
         b_sneg_ff <= a_s_ff[31];
      end
   end

   // ---------------- stage C: magnitudes and signs
   logic        c_v_ff;
   logic [32:0] c_xm_ff, c_xm_in;
   logic [32:0] c_dm_ff, c_dm_in;
   dctl_type    c_ctl_ff, c_ctl_in;

   always_comb begin
      c_xm_in = b_x_ff[33] ? 33'(-b_x_ff) : b_x_ff[32:0];
      c_dm_in = b_den_ff[33] ? 33'(-b_den_ff) : b_den_ff[32:0];
      c_ctl_in.op   = b_op_ff;
      c_ctl_in.zden = (b_den_ff == '0);
      c_ctl_in.nden = b_den_ff[33];
      c_ctl_in.neg  = b_x_ff[33] ^ b_den_ff[33];
      c_ctl_in.sat  = 1'b0;
      c_ctl_in.sneg = b_sneg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else if (adv) c_v_ff <= b_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c_xm_ff  <= c_xm_in;
         c_dm_ff  <= c_dm_in;
         c_ctl_ff <= c_ctl_in;
      end
   end

   // ---------------- divider: stage 0 scales the dividend and checks overflow
   logic [QW:0]    dv_v_ff;
   logic [NW-1:0]  dv_rem_ff [QW+1];
   logic [32:0]    dv_dm_ff  [QW+1];
   logic [QW-1:0]  dv_q_ff   [QW+1];
   dctl_type       dv_ctl_ff [QW+1];

   logic [NW-1:0]  d_num_in;
   dctl_type       d_ctl_in;

   always_comb begin
      if (c_ctl_ff.op == OP_GREY) d_num_in = (NW'(c_xm_ff) << 8) - NW'(c_xm_ff);
      else d_num_in = NW'(c_xm_ff) << 16;
      d_ctl_in     = c_ctl_ff;
      d_ctl_in.sat = d_num_in >= (NW'(c_dm_ff) << QW);
   end

   always_ff @(posedge clock) begin
      if (reset) dv_v_ff[0] <= 1'b0;
      else if (adv) dv_v_ff[0] <= c_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0] <= d_num_in;
         dv_dm_ff[0]  <= c_dm_ff;
         dv_q_ff[0]   <= '0;
         dv_ctl_ff[0] <= d_ctl_in;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [NW-1:0] bound;
      logic          ge;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] q_in;

      always_comb begin
         bound  = NW'(dv_dm_ff[j]) << (QW - 1 - j);
         ge     = dv_rem_ff[j] >= bound;
         rem_in = ge ? (dv_rem_ff[j] - bound) : dv_rem_ff[j];
         q_in   = dv_q_ff[j];
         q_in[QW-1-j] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[j+1] <= 1'b0;
         else if (adv) dv_v_ff[j+1] <= dv_v_ff[j];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[j+1] <= rem_in;
            dv_dm_ff[j+1]  <= dv_dm_ff[j];
            dv_q_ff[j+1]   <= q_in;
            dv_ctl_ff[j+1] <= dv_ctl_ff[j];
         end
      end
   end

   // ---------------- stage E: clamp quotient per palette
   logic        e_v_ff;
   op_type      e_op_ff;
   logic        e_black_ff, e_black_in;
   logic        e_sneg_ff;
   logic [16:0] e_val_ff, e_val_in;
   logic [QW-1:0] e_q;
   dctl_type    e_ctl;

   always_comb begin
      e_q   = dv_q_ff[QW];
      e_ctl = dv_ctl_ff[QW];
      e_black_in = 1'b0;
      case (e_ctl.op)
         OP_RAINBOW, OP_VELOCITY: begin
            if (e_ctl.zden) e_val_in = 17'd32768;
            else if (e_ctl.nden) e_val_in = '0;
            else e_val_in = e_q;
         end
         OP_GREY: begin
            if (e_ctl.zden || e_ctl.neg) e_val_in = '0;
            else if (e_ctl.sat || e_q > 17'd255) e_val_in = 17'd255;
            else e_val_in = e_q;
         end
         OP_HEAT: begin
            e_black_in = e_ctl.zden;
            if (e_ctl.zden || e_ctl.neg) e_val_in = '0;
            else if (e_ctl.sat || e_q > 17'd65536) e_val_in = 17'd65536;
            else e_val_in = e_q;
         end
         OP_DIVERGE: begin
            if (e_ctl.sat || e_q > 17'd65536) e_val_in = 17'd65536;
            else e_val_in = e_q;
         end
         default: begin
            e_black_in = 1'b1;
            e_val_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else if (adv) e_v_ff <= dv_v_ff[QW];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         e_op_ff    <= e_ctl.op;
         e_black_ff <= e_black_in;
         e_sneg_ff  <= e_ctl.sneg;
         e_val_ff   <= e_val_in;
      end
   end

   // ---------------- stage F: simple palettes, heatmap numerators, table index product
   logic        f_v_ff;
   op_type      f_op_ff;
   logic        f_black_ff;
   logic        f_sneg_ff;
   rgb_type     f_rgb_ff, f_rgb_in;
   logic [15:0] f_xa_ff, f_xa_in, f_xb_ff, f_xb_in;
   hseg_type    f_hseg_ff, f_hseg_in;
   logic [PW-1:0] f_prod_ff, f_prod_in;
   logic [13:0] rb_s;
   logic [7:0]  rb_up, rb_down;
   logic [7:0]  vel_g;
   logic [31:0] heat_h;

   always_comb begin
      // rainbow ramp
      rb_s    = e_val_ff[13:0];
      rb_up   = 8'((22'(rb_s) * 22'd255) >> 14);
      rb_down = 8'(((22'd16384 - 22'(rb_s)) * 22'd255) >> 14);
      // velocity green
      if (e_val_ff < 17'd32768) vel_g = 8'((26'(e_val_ff) * 26'd330) >> 16);
      else vel_g = 8'd165 + 8'(((26'(e_val_ff) - 26'd32768) * 26'd180) >> 16);
      // heatmap numerators, already shifted down by 16
      heat_h  = 32'(e_val_ff) * 32'd100;
      f_xb_in = '0;
      if (heat_h < H33) begin
         f_hseg_in = HS_LOW;
         f_xa_in   = 16'((heat_h * 32'd255) >> 16);
      end else if (heat_h < H66) begin
         f_hseg_in = HS_MID;
         f_xa_in   = 16'(((heat_h - H33) * 32'd255) >> 16);
         f_xb_in   = 16'(((H66 - heat_h) * 32'd255) >> 16);
      end else begin
         f_hseg_in = HS_HIGH;
         f_xa_in   = 16'(((H136 - 32'd3 * (heat_h - H66)) * 32'd255) >> 16);
      end
      // divergence table index before rounding shift
      f_prod_in = PW'(e_val_ff) * PW'(DEN_T) + PW'(32768);

      f_rgb_in = '0;
      case (e_op_ff)
         OP_RAINBOW: begin
            case (e_val_ff[15:14])
               2'd0:    f_rgb_in = '{8'd0, rb_up, 8'd255};
               2'd1:    f_rgb_in = '{8'd0, 8'd255, rb_down};
               2'd2:    f_rgb_in = '{rb_up, 8'd255, 8'd0};
               default: f_rgb_in = '{8'd255, rb_down, 8'd0};
            endcase
         end
         OP_GREY:     f_rgb_in = '{e_val_ff[7:0], e_val_ff[7:0], e_val_ff[7:0]};
         OP_VELOCITY: f_rgb_in = '{8'd255, vel_g, 8'd0};
         default:     f_rgb_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) f_v_ff <= 1'b0;
      else if (adv) f_v_ff <= e_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         f_op_ff    <= e_op_ff;
         f_black_ff <= e_black_ff;
         f_sneg_ff  <= e_sneg_ff;
         f_rgb_ff   <= f_rgb_in;
         f_xa_ff    <= f_xa_in;
         f_xb_ff    <= f_xb_in;
         f_hseg_ff  <= f_hseg_in;
         f_prod_ff  <= f_prod_in;
      end
   end

   // ---------------- stage G: reciprocal products, table read
   logic        g_v_ff;
   op_type      g_op_ff;
   logic        g_black_ff;
   logic        g_sneg_ff;
   rgb_type     g_rgb_ff;
   logic [32:0] g_pa_ff, g_pa_in, g_pb_ff, g_pb_in;
   hseg_type    g_hseg_ff;
   logic [16:0] g_mag_ff, g_mag_in;
   logic [PW-17:0] g_idx_raw;
   logic [IW-1:0]  g_idx;

   always_comb begin
      g_pa_in = 33'(f_xa_ff) * 33'((f_hseg_ff == HS_HIGH) ? K136 : K33);
      g_pb_in = 33'(f_xb_ff) * 33'(K33);
      g_idx_raw = f_prod_ff[PW-1:16];
      if (g_idx_raw >= (PW-16)'(N_ENT)) g_idx = IW'(N_ENT - 1);
      else g_idx = g_idx_raw[IW-1:0];
      g_mag_in = pow_rom[g_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) g_v_ff <= 1'b0;
      else if (adv) g_v_ff <= f_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         g_op_ff    <= f_op_ff;
         g_black_ff <= f_black_ff;
         g_sneg_ff  <= f_sneg_ff;
         g_rgb_ff   <= f_rgb_ff;
         g_pa_ff    <= g_pa_in;
         g_pb_ff    <= g_pb_in;
         g_hseg_ff  <= f_hseg_ff;
         g_mag_ff   <= g_mag_in;
      end
   end

   // ---------------- stage H: heatmap result, divergence tint sums
   logic        h_v_ff;
   op_type      h_op_ff;
   rgb_type     h_rgb_ff, h_rgb_in;
   logic [17:0] h_y_ff [3];
   logic [17:0] h_y_in [3];
   logic [7:0]  h_qa, h_qb;
   logic [26:0] h_sum [3];

   always_comb begin
      h_qa = 8'(g_pa_ff >> KSH);
      h_qb = 8'(g_pb_ff >> KSH);
      h_rgb_in = g_rgb_ff;
      if (g_op_ff == OP_HEAT && !g_black_ff) begin
         case (g_hseg_ff)
            HS_LOW:  h_rgb_in = '{8'd0, h_qa, 8'd255};
            HS_MID:  h_rgb_in = '{h_qa, 8'd255, h_qb};
            default: h_rgb_in = '{8'd255, h_qa, 8'd0};
         endcase
      end
      for (int k = 0; k < 3; k++) begin
         h_sum[k] = (27'(DIV_BASE[k]) << 16)
                  + 27'(g_sneg_ff ? DIV_TINT_NEG[k] : DIV_TINT_POS[k]) * 27'(g_mag_ff);
         if (h_sum[k] > DIV_FULL) h_sum[k] = DIV_FULL;
         h_y_in[k] = 18'(((35'(h_sum[k]) << 8) - 35'(h_sum[k])) >> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) h_v_ff <= 1'b0;
      else if (adv) h_v_ff <= g_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         h_op_ff  <= g_op_ff;
         h_rgb_ff <= h_rgb_in;
         h_y_ff   <= h_y_in;
      end
   end

   // ---------------- stage I: divide by 1000 via reciprocal
   logic        i_v_ff;
   op_type      i_op_ff;
   rgb_type     i_rgb_ff;
   logic [36:0] i_z_ff [3];
   logic [36:0] i_z_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) i_z_in[k] = 37'(h_y_ff[k]) * 37'(K1000);
   end

   always_ff @(posedge clock) begin
      if (reset) i_v_ff <= 1'b0;
      else if (adv) i_v_ff <= h_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         i_op_ff  <= h_op_ff;
         i_rgb_ff <= h_rgb_ff;
         i_z_ff   <= i_z_in;
      end
   end

   // ---------------- output register
   rgb_type rsp_rgb_ff, rsp_rgb_in;

   always_comb begin
      if (i_op_ff == OP_DIVERGE)
         rsp_rgb_in = '{8'(i_z_ff[0] >> K1000_SH), 8'(i_z_ff[1] >> K1000_SH),
                        8'(i_z_ff[2] >> K1000_SH)};
      else
         rsp_rgb_in = i_rgb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= i_v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) rsp_rgb_ff <= rsp_rgb_in;
   end

   assign rsp_red   = rsp_rgb_ff.r;
   assign rsp_green = rsp_rgb_ff.g;
   assign rsp_blue  = rsp_rgb_ff.b;

endmodule
